>>> hdl/nonpreemptive_priority_scheduler_defines.svh
// Assertion macros shared by the scheduler RTL.
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define NPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// next-cycle implication, sampled on clk, off during reset
`define NPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

>>> hdl/nps_pkg.sv
// Shared constants and types for the priority scheduler.
`timescale 1ns / 1ps

package nps_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] burst;
        logic [7:0]  prio;
        logic [31:0] age;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } tbl_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } tbl_rd_t;

endpackage

>>> hdl/nps_table.sv
// Ready table storage: one write port, one registered read port.
`timescale 1ns / 1ps

module nps_table
(
    input  logic             clk,
    input  nps_pkg::tbl_wr_t wr,
    input  nps_pkg::tbl_rd_t rd,
    output nps_pkg::entry_t  rd_data
);
    import nps_pkg::*;

    entry_t mem [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

>>> hdl/nonpreemptive_priority_scheduler.sv
// Top level of the non-preemptive priority scheduler.
//
//  channel   handshake               word
//  input     start & !busy           kind, process_id, burst_length, prio_level
//  result    done (one cycle)        dispatched, dropped, run_id, start_time, end_time
//
// Arrival words and ticks that dispatch nothing are handled in S_IDLE; the result shows
// the cycle after acceptance. A tick that dispatches scans the table through its
// single read port in S_SCAN, then reports its pick in S_DISP before busy drops.
// Reset clears valid bits, clocks and the CPU state; table contents stay undefined.
// The receiver cannot stall; done is high for exactly one cycle per word.
`timescale 1ns / 1ps
`include "nonpreemptive_priority_scheduler_defines.svh"

module nonpreemptive_priority_scheduler
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic [15:0] process_id,
    input  logic [15:0] burst_length,
    input  logic [7:0]  prio_level,
    output logic        done,
    output logic        dispatched,
    output logic        dropped,
    output logic [15:0] run_id,
    output logic [31:0] start_time,
    output logic [31:0] end_time
);
    import nps_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DISP = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [QUEUE_DEPTH-1:0] valid_reg, valid_next;
    logic [31:0]            arrival_cnt_reg, arrival_cnt_next;
    logic [31:0]            now_reg, now_next;
    logic                   cpu_busy_reg, cpu_busy_next;
    logic [31:0]            busy_until_reg, busy_until_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   found_reg, found_next;
    logic                   done_reg, done_next;

    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [15:0]            best_id_reg, best_id_next;
    logic [15:0]            best_burst_reg, best_burst_next;
    logic [7:0]             best_prio_reg, best_prio_next;
    logic [31:0]            best_old_reg, best_old_next;

    logic                   dispatched_reg, dispatched_next;
    logic                   dropped_reg, dropped_next;
    logic [15:0]            run_id_reg, run_id_next;
    logic [31:0]            start_time_reg, start_time_next;
    logic [31:0]            end_time_reg, end_time_next;

    tbl_wr_t                wr;
    tbl_rd_t                rd;
    entry_t                 rd_data;
    logic                   wr_en;

    logic                   free_found;
    logic [IDX_W-1:0]       free_idx;
    logic [IDX_W-1:0]       cmp_idx;
    logic [31:0]            cand_old;
    logic                   cand_better;
    logic                   release_now;
    logic                   cpu_free;

    nps_table u_table
    (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // read data is registered, so it lags the address
    assign cmp_idx  = IDX_W'(cnt_reg - CNT_W'(1));
    assign cand_old = arrival_cnt_reg - rd_data.age;

    always_comb
    begin
        if (rd_data.prio != best_prio_reg)
        begin
            cand_better = rd_data.prio < best_prio_reg;
        end
        else if (rd_data.burst != best_burst_reg)
        begin
            cand_better = rd_data.burst < best_burst_reg;
        end
        else
        begin
            cand_better = cand_old > best_old_reg;
        end
    end

    assign release_now = cpu_busy_reg && (busy_until_reg == now_reg);
    assign cpu_free    = !cpu_busy_reg || release_now;

    assign rd.en   = (state_reg == S_SCAN) && (cnt_reg < CNT_W'(QUEUE_DEPTH));
    assign rd.addr = cnt_reg[IDX_W-1:0];

    assign wr.en         = wr_en;
    assign wr.addr       = free_idx;
    assign wr.data.id    = process_id;
    assign wr.data.burst = burst_length;
    assign wr.data.prio  = prio_level;
    assign wr.data.age   = arrival_cnt_reg;

    always_comb
    begin
        state_next       = state_reg;
        valid_next       = valid_reg;
        arrival_cnt_next = arrival_cnt_reg;
        now_next         = now_reg;
        cpu_busy_next    = cpu_busy_reg;
        busy_until_next  = busy_until_reg;
        cnt_next         = cnt_reg;
        found_next       = found_reg;
        done_next        = 1'b0;
        best_idx_next    = best_idx_reg;
        best_id_next     = best_id_reg;
        best_burst_next  = best_burst_reg;
        best_prio_next   = best_prio_reg;
        best_old_next    = best_old_reg;
        dispatched_next  = dispatched_reg;
        dropped_next     = dropped_reg;
        run_id_next      = run_id_reg;
        start_time_next  = start_time_reg;
        end_time_next    = end_time_reg;
        wr_en            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (!kind)
                    begin
                        done_next       = 1'b1;
                        dispatched_next = 1'b0;
                        dropped_next    = 1'b0;
                        run_id_next     = '0;
                        start_time_next = '0;
                        end_time_next   = '0;
                        // zero burst: ignored, no age taken
                        if (burst_length != 16'd0)
                        begin
                            if (free_found)
                            begin
                                wr_en                = 1'b1;
                                valid_next[free_idx] = 1'b1;
                                arrival_cnt_next     = arrival_cnt_reg + 32'd1;
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                    end
                    else if (cpu_free && (|valid_reg))
                    begin
                        cpu_busy_next = 1'b0;
                        cnt_next      = '0;
                        found_next    = 1'b0;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        cpu_busy_next   = cpu_busy_reg && !release_now;
                        done_next       = 1'b1;
                        dispatched_next = 1'b0;
                        dropped_next    = 1'b0;
                        run_id_next     = '0;
                        start_time_next = '0;
                        end_time_next   = '0;
                        now_next        = now_reg + 32'd1;
                    end
                end
            end
            S_SCAN:
            begin
                if ((cnt_reg != '0) && valid_reg[cmp_idx] && (!found_reg || cand_better))
                begin
                    found_next      = 1'b1;
                    best_idx_next   = cmp_idx;
                    best_id_next    = rd_data.id;
                    best_burst_next = rd_data.burst;
                    best_prio_next  = rd_data.prio;
                    best_old_next   = cand_old;
                end
                if (cnt_reg == CNT_W'(QUEUE_DEPTH))
                begin
                    state_next = S_DISP;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_DISP:
            begin
                valid_next[best_idx_reg] = 1'b0;
                cpu_busy_next   = 1'b1;
                busy_until_next = now_reg + {16'd0, best_burst_reg};
                done_next       = 1'b1;
                dispatched_next = 1'b1;
                dropped_next    = 1'b0;
                run_id_next     = best_id_reg;
                start_time_next = now_reg;
                end_time_next   = now_reg + {16'd0, best_burst_reg};
                now_next        = now_reg + 32'd1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            valid_reg       <= '0;
            arrival_cnt_reg <= '0;
            now_reg         <= '0;
            cpu_busy_reg    <= 1'b0;
            busy_until_reg  <= '0;
            cnt_reg         <= '0;
            found_reg       <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            valid_reg       <= valid_next;
            arrival_cnt_reg <= arrival_cnt_next;
            now_reg         <= now_next;
            cpu_busy_reg    <= cpu_busy_next;
            busy_until_reg  <= busy_until_next;
            cnt_reg         <= cnt_next;
            found_reg       <= found_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg   <= best_idx_next;
        best_id_reg    <= best_id_next;
        best_burst_reg <= best_burst_next;
        best_prio_reg  <= best_prio_next;
        best_old_reg   <= best_old_next;
        dispatched_reg <= dispatched_next;
        dropped_reg    <= dropped_next;
        run_id_reg     <= run_id_next;
        start_time_reg <= start_time_next;
        end_time_reg   <= end_time_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign dispatched = dispatched_reg;
    assign dropped    = dropped_reg;
    assign run_id     = run_id_reg;
    assign start_time = start_time_reg;
    assign end_time   = end_time_reg;

    `NPS_ASSERT_NEXT(a_arrival_result, start && !busy && !kind, done && !dispatched)
    `NPS_ASSERT_NOW(a_disp_has_pick, state_reg == S_DISP, found_reg)
    `NPS_ASSERT_NOW(a_flags_exclusive, done, !(dispatched && dropped))
    `NPS_ASSERT_NOW(a_end_tracked, done && dispatched, cpu_busy_reg && (busy_until_reg == end_time))

endmodule
